// ===== src/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types and constants for the UDP payload signature classifier.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int unsigned HeadLen  = 21;
  localparam int unsigned TagFirst = 94;
  localparam int unsigned TagLen   = 8;

  localparam logic [15:0] ServicePortReset = 16'd17788;
  localparam logic [15:0] CountMax         = 16'hffff;
  localparam logic [15:0] PosMax           = 16'hffff;

  // opcode and signature bytes
  localparam logic [7:0] OpA      = 8'h43;
  localparam logic [7:0] OpB      = 8'h44;
  localparam logic [7:0] OpC      = 8'h55;
  localparam logic [7:0] SigB1    = 8'hb1;
  localparam logic [7:0] Sig71    = 8'h71;
  localparam logic [7:0] Sig73    = 8'h73;
  localparam logic [7:0] Sig17    = 8'h17;
  localparam logic [7:0] Sig74    = 8'h74;
  localparam logic [7:0] Sig80    = 8'h80;
  localparam logic [7:0] Sig84    = 8'h84;
  localparam logic [7:0] Sig53    = 8'h53;
  localparam logic [7:0] Sig1b    = 8'h1b;
  localparam logic [7:0] SigA0    = 8'ha0;
  localparam logic [15:0] TagLenMatch = 16'd113;

  // marker expected in the tag window, byte 0 in the lowest slot
  localparam logic [TagLen-1:0][7:0] Marker = {
    8'h6d, 8'h61, 8'h65, 8'h72, 8'h74, 8'h53, 8'h50, 8'h50
  };

  typedef enum logic [1:0] {
    VERDICT_NOT_UDP  = 2'd0,
    VERDICT_DETECTED = 2'd1,
    VERDICT_EXCLUDED = 2'd2
  } verdict_e;

  // one finished packet, as handed to the classifier
  typedef struct packed {
    logic                      is_udp;
    logic [15:0]               src_port;
    logic [15:0]               dst_port;
    logic [15:0]               payload_len;
    logic [HeadLen-1:0][7:0]   head;
    logic [TagLen-1:0][7:0]    tag;
  } pkt_t;

endpackage

// ===== src/upc_classify.sv =====
// ----------------------------------------------------------------------------
// upc_classify
// Signature match on one captured packet: port path, then the
// port-independent checks on the leading bytes.
// ----------------------------------------------------------------------------
module upc_classify (
  input  upc_pkg::pkt_t pkt_i,
  input  logic [15:0]   service_port_i,
  output logic          match_o
);
  import upc_pkg::*;

  logic [15:0] len;
  logic [15:0] word;
  logic        gate_ok;
  logic        word_ok;
  logic        hit_a;
  logic        hit_b;
  logic        hit_b1;
  logic        hit_b73;
  logic        hit_b74;
  logic        hit_c1;
  logic        hit_c2;
  logic        port_hit;
  logic        tail_hit;
  logic [HeadLen-1:0][7:0] h;

  always_comb begin
    h    = pkt_i.head;
    len  = pkt_i.payload_len;
    word = {h[1], h[0]};

    gate_ok = (len > 16'd12) &&
              ((pkt_i.src_port == service_port_i) || (pkt_i.dst_port == service_port_i));
    // len is above 12 whenever this matters, so the subtractions cannot wrap
    word_ok = (word == len - 16'd4) || (word == len) || (word == len - 16'd6);

    hit_a = (h[2] == OpA) && (h[5] == 8'hff) && (h[6] == 8'h00) && (h[7] == 8'h01) &&
            (h[14:8] == '0);

    hit_b1 = (h[3] == SigB1) && (h[4] == Sig71) &&
             (h[13] == 8'h00) && (h[14] == 8'h00) && (h[15] == 8'h01) && (h[16] == 8'h00) &&
             (((h[17] >= 8'h02) && (h[17] <= 8'h05) && (h[20:18] == '0)) ||
              ((h[17] == 8'hff) && (h[18] == 8'hff) && (h[19] == 8'hff) &&
               (h[20] == 8'hff)));
    hit_b73 = (h[3] == Sig73) && (h[4] == Sig17) && (h[8:5] == '0) && (h[20:14] == '0);
    hit_b74 = (h[3] == Sig74) && (h[4] == Sig71) && (len == TagLenMatch) &&
              (pkt_i.tag == Marker);
    hit_b   = (h[2] == OpB) && (hit_b1 || hit_b73 || hit_b74);

    hit_c1 = (h[2] == OpC) && (h[13] == Sig1b) && (h[14] == SigA0) && (h[20:15] == '0);
    hit_c2 = (h[2] == OpC) && (h[1] == 8'h00) && (h[8:5] == '0) && (h[20:14] == '0);

    port_hit = word_ok && (hit_a || hit_b || hit_c1 || hit_c2);

    // a 0x80/0x84 second byte settles the answer on its own
    if ((h[1] == Sig80) || (h[1] == Sig84)) begin
      tail_hit = (h[3] == h[4]);
    end else begin
      tail_hit = (h[1] == Sig53) && (h[3] == 8'h00) &&
                 ((h[0] == 8'h08) || (h[0] == 8'h0c));
    end

    match_o = gate_ok && (port_hit || ((len > 16'd17) && tail_hit));
  end

endmodule

// ===== src/udp_payload_signature_classifier.sv =====
// ----------------------------------------------------------------------------
// udp_payload_signature_classifier
// Per-packet payload signature classifier with a saturating detection count.
// ----------------------------------------------------------------------------
// Payload bytes stream in one item per cycle with the packet's header fields;
// every cycle can take a new byte while the input is not stalled (see below).
// Bytes 0 to 20 and 94 to 101 are captured. The item marked tlast closes the
// packet: its capture is copied into a packet register, classified by one
// stage of compare logic, and the verdict with the updated detection count is
// loaded into the output register once that register is free. The output
// register and the packet register let the next packet stream in while a
// verdict waits to be taken; input stalls only while both hold a verdict that
// has not been taken. Bytes at or past payload_len are captured as zero.
// service_port is written through the cfg channel, which is always ready.
module udp_payload_signature_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // service_port
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] src_port, [31:16] dst_port, [47:32] payload_len, [55:48] data_byte
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // [0] is_udp
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] verdict, [17:2] detections, [23:18] zero
  output logic [23:0] m_axis_tdata
);
  import upc_pkg::*;

  logic [15:0]             service_port_q;
  logic [15:0]             pos_q, pos_d;
  logic [HeadLen-1:0][7:0] head_q, head_d;
  logic [TagLen-1:0][7:0]  tag_q, tag_d;
  pkt_t                    snap_q;
  logic                    snap_valid_q;
  logic                    out_valid_q;
  verdict_e                out_verdict_q;
  logic [15:0]             out_count_q;
  logic [15:0]             count_q, count_d;
  verdict_e                verdict_d;

  logic        in_acc;
  logic        out_free;
  logic        snap_adv;
  logic        match;
  logic [15:0] in_len;
  logic [7:0]  in_byte;
  logic [7:0]  cap_byte;
  logic [15:0] tag_off;

  assign cfg_ready_o = 1'b1;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign snap_adv      = snap_valid_q && out_free;
  assign s_axis_tready = !snap_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_len   = s_axis_tdata[47:32];
  assign in_byte  = s_axis_tdata[55:48];
  assign cap_byte = (pos_q < in_len) ? in_byte : 8'h00;
  assign tag_off  = pos_q - 16'(TagFirst);

  always_comb begin
    head_d = head_q;
    tag_d  = tag_q;
    if (pos_q < 16'(HeadLen)) begin
      head_d[pos_q[4:0]] = cap_byte;
    end else if ((pos_q >= 16'(TagFirst)) && (pos_q < 16'(TagFirst + TagLen))) begin
      tag_d[tag_off[2:0]] = cap_byte;
    end
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_port_q <= ServicePortReset;
    end else if (cfg_valid_i) begin
      service_port_q <= cfg_data_i;
    end
  end

  // capture side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      head_q <= '0;
      tag_q  <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        pos_q  <= '0;
        head_q <= '0;
        tag_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        head_q <= head_d;
        tag_q  <= tag_d;
      end
    end
  end

  // packet register: hold the finished capture until the result stage frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      snap_valid_q <= 1'b1;
    end else if (snap_adv) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      snap_q.is_udp      <= s_axis_tuser;
      snap_q.src_port    <= s_axis_tdata[15:0];
      snap_q.dst_port    <= s_axis_tdata[31:16];
      snap_q.payload_len <= in_len;
      snap_q.head        <= head_d;
      snap_q.tag         <= tag_d;
    end
  end

  upc_classify u_classify (
    .pkt_i          (snap_q),
    .service_port_i (service_port_q),
    .match_o        (match)
  );

  always_comb begin
    count_d = count_q;
    if (!snap_q.is_udp) begin
      verdict_d = VERDICT_NOT_UDP;
    end else if (match) begin
      verdict_d = VERDICT_DETECTED;
      if (count_q != CountMax) begin
        count_d = count_q + 16'd1;
      end
    end else begin
      verdict_d = VERDICT_EXCLUDED;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (snap_adv) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv) begin
      out_verdict_q <= verdict_d;
      out_count_q   <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_count_q, out_verdict_q};

endmodule

// ===== src/upc_checker.sv =====
// ----------------------------------------------------------------------------
// upc_checker
// Port-level checks on the classifier: verdict codes, output stall and the
// way the detection count moves from one verdict to the next.
// ----------------------------------------------------------------------------
module upc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import upc_pkg::*;

  logic        out_acc;
  logic [1:0]  verdict;
  logic [15:0] count;
  logic [15:0] prev_count_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign verdict = m_axis_tdata[1:0];
  assign count   = m_axis_tdata[17:2];

  // track the count shown with the last verdict taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
    end else if (out_acc) begin
      prev_count_q <= count;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (verdict == VERDICT_NOT_UDP || verdict == VERDICT_DETECTED ||
                       verdict == VERDICT_EXCLUDED))
    else $error("verdict code out of range");

  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && verdict != VERDICT_DETECTED) |-> (count == prev_count_q))
    else $error("count moved without a detection");

  a_count_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && verdict == VERDICT_DETECTED) |->
      ((count == prev_count_q + 16'd1) || (prev_count_q == CountMax && count == CountMax)))
    else $error("count did not advance on a detection");

endmodule

bind udp_payload_signature_classifier upc_checker u_upc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_udp_payload_signature_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_udp_payload_signature_classifier
// Self-checking bench for the UDP payload signature classifier.
// ----------------------------------------------------------------------------
// Payload bytes are streamed in packet by packet with random gaps on the
// input and random stalls on the verdict side. A predictor of the capture
// windows, the signature checks and the detection counter works out the
// verdict for every packet; each verdict item taken from the block is checked
// against the oldest one waiting. Directed packets cover field extremes and
// the short, overlong and zero-length cases, then every signature pattern,
// several service ports, random traffic with corrupted signatures, and a
// closing stretch of back-to-back traffic with no idling on either side.
// ----------------------------------------------------------------------------
module tb_udp_payload_signature_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import upc_pkg::*;

  typedef enum int unsigned {
    KIND_NOISE, KIND_OPA, KIND_OPB_B1, KIND_OPB_73, KIND_OPB_74,
    KIND_OPC_1B, KIND_OPC_ZERO, KIND_HI80, KIND_H53
  } sig_kind_e;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] detections;
  } class_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // predictor state
  logic [15:0] svc_port;
  logic [15:0] pos_cnt;
  logic [15:0] det_cnt;
  logic [7:0]  head_q [HeadLen];
  logic [7:0]  tag_q  [TagLen];
  class_result_t pending_verdicts [$];

  // packet under construction
  logic        pkt_udp;
  logic [15:0] pkt_sp, pkt_dp, pkt_len;
  logic [7:0]  pkt_bytes [$];

  int unsigned idle_pct_in  = 0;
  int unsigned idle_pct_out = 0;
  int unsigned ready_hold   = 0;
  int unsigned error_cnt    = 0;
  int unsigned items_sent   = 0;
  int unsigned packets_sent = 0;
  int unsigned verdicts_checked = 0;
  int unsigned port_writes  = 0;

  udp_payload_signature_classifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("[udp_payload_signature_classifier] ERROR");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic bit head_zero(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i <= hi; i++) begin
      if (head_q[i] != 8'h00) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit opcode_b_hit(input int unsigned len);
    if (head_q[3] == SigB1 && head_q[4] == Sig71) begin
      if (head_q[13] == 8'h00 && head_q[14] == 8'h00 && head_q[15] == 8'h01 &&
          head_q[16] == 8'h00) begin
        if (head_q[17] >= 8'h02 && head_q[17] <= 8'h05) return head_zero(18, 20);
        if (head_q[17] == 8'hff)
          return head_q[18] == 8'hff && head_q[19] == 8'hff && head_q[20] == 8'hff;
      end
      return 1'b0;
    end
    if (head_q[3] == Sig73 && head_q[4] == Sig17) return head_zero(5, 8) && head_zero(14, 20);
    if (head_q[3] == Sig74 && head_q[4] == Sig71 && len == TagLenMatch) begin
      foreach (tag_q[i]) begin
        if (tag_q[i] != Marker[i]) return 1'b0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit signature_hit(input int unsigned len, input logic [15:0] sp,
                                       input logic [15:0] dp);
    int unsigned word;
    if (!(len > 12 && (sp == svc_port || dp == svc_port))) return 1'b0;
    word = {head_q[1], head_q[0]};
    if (len - 4 == word || len == word || len - 6 == word) begin
      if (head_q[2] == OpA) begin
        if (head_q[5] == 8'hff && head_q[6] == 8'h00 && head_q[7] == 8'h01 &&
            head_zero(8, 14)) return 1'b1;
      end else if (head_q[2] == OpB) begin
        if (opcode_b_hit(len)) return 1'b1;
      end else if (head_q[2] == OpC && head_q[13] == Sig1b && head_q[14] == SigA0 &&
                   head_zero(15, 20)) begin
        return 1'b1;
      end else if (head_q[2] == OpC && head_q[1] == 8'h00 && head_zero(5, 8) &&
                   head_zero(14, 20)) begin
        return 1'b1;
      end
    end
    // port-independent patterns, still behind the port match
    if (len > 17) begin
      if (head_q[1] == Sig80 || head_q[1] == Sig84) return head_q[3] == head_q[4];
      if (head_q[1] == Sig53 && head_q[3] == 8'h00 &&
          (head_q[0] == 8'h08 || head_q[0] == 8'h0c)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_capture();
    pos_cnt = '0;
    foreach (head_q[i]) head_q[i] = '0;
    foreach (tag_q[i]) tag_q[i] = '0;
  endtask

  task automatic predict_byte(input logic udp, input logic [15:0] sp, input logic [15:0] dp,
                              input logic [15:0] len, input logic [7:0] b, input logic last);
    logic [7:0]    v;
    class_result_t want;
    v = (pos_cnt < len) ? b : 8'h00;
    if (pos_cnt < HeadLen) head_q[pos_cnt] = v;
    else if (pos_cnt >= TagFirst && pos_cnt < TagFirst + TagLen) tag_q[pos_cnt - TagFirst] = v;
    if (pos_cnt != PosMax) pos_cnt++;
    if (last) begin
      if (!udp) begin
        want.verdict = VERDICT_NOT_UDP;
      end else if (signature_hit(len, sp, dp)) begin
        want.verdict = VERDICT_DETECTED;
        if (det_cnt != CountMax) det_cnt++;
      end else begin
        want.verdict = VERDICT_EXCLUDED;
      end
      want.detections = det_cnt;
      pending_verdicts.push_back(want);
      clear_capture();
    end
  endtask

  // ------------------------------------------------------------------ drivers

  task automatic send_item(input logic udp, input logic [15:0] sp, input logic [15:0] dp,
                           input logic [15:0] len, input logic [7:0] b, input logic last);
    if (idle_pct_in != 0 && $urandom_range(99) < idle_pct_in) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, len, dp, sp};
    s_axis_tuser  <= udp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    items_sent++;
    predict_byte(udp, sp, dp, len, b, last);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i])
      send_item(pkt_udp, pkt_sp, pkt_dp, pkt_len, pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // drop valid and wait until every verdict is back and the pipeline is empty
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_service_port(input logic [15:0] port);
    drain_verdicts();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= port;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    svc_port = port;
    port_writes++;
  endtask

  // well-formed signature with random content, optionally with one byte spoiled
  task automatic build_packet(input sig_kind_e kind, input bit corrupt);
    logic [7:0]  h [HeadLen];
    logic [7:0]  t [TagLen];
    logic [15:0] w;
    int unsigned n, r, k;
    foreach (h[i]) h[i] = 8'($urandom);
    foreach (t[i]) t[i] = 8'($urandom);
    r = $urandom_range(15);
    if (kind == KIND_OPB_74) pkt_len = TagLenMatch;
    else if (kind == KIND_OPC_ZERO) pkt_len = 16'($urandom_range(200, 13));
    else if (r == 0) pkt_len = 16'($urandom_range(12, 1));
    else if (r == 1) pkt_len = 16'($urandom_range(65535, 13));
    else pkt_len = 16'($urandom_range(60, 13));
    case ($urandom_range(2))
      0: w = pkt_len;
      1: w = pkt_len - 16'd4;
      default: w = pkt_len - 16'd6;
    endcase
    h[0] = w[7:0];
    h[1] = w[15:8];
    case (kind)
      KIND_OPA: begin
        h[2] = OpA; h[5] = 8'hff; h[6] = 8'h00; h[7] = 8'h01;
        for (int i = 8; i <= 14; i++) h[i] = 8'h00;
      end
      KIND_OPB_B1: begin
        h[2] = OpB; h[3] = SigB1; h[4] = Sig71;
        h[13] = 8'h00; h[14] = 8'h00; h[15] = 8'h01; h[16] = 8'h00;
        case ($urandom_range(2))
          0: begin
            h[17] = 8'($urandom_range(5, 2));
            for (int i = 18; i <= 20; i++) h[i] = 8'h00;
          end
          1: for (int i = 17; i <= 20; i++) h[i] = 8'hff;
          default: ;
        endcase
      end
      KIND_OPB_73: begin
        h[2] = OpB; h[3] = Sig73; h[4] = Sig17;
        for (int i = 5; i <= 8; i++) h[i] = 8'h00;
        for (int i = 14; i <= 20; i++) h[i] = 8'h00;
      end
      KIND_OPB_74: begin
        h[2] = OpB; h[3] = Sig74; h[4] = Sig71;
        foreach (t[i]) t[i] = Marker[i];
      end
      KIND_OPC_1B: begin
        h[2] = OpC; h[13] = Sig1b; h[14] = SigA0;
        for (int i = 15; i <= 20; i++) h[i] = 8'h00;
      end
      KIND_OPC_ZERO: begin
        h[2] = OpC;
        for (int i = 5; i <= 8; i++) h[i] = 8'h00;
        for (int i = 14; i <= 20; i++) h[i] = 8'h00;
      end
      KIND_HI80: begin
        h[1] = $urandom_range(1) ? Sig80 : Sig84;
        h[4] = h[3];
      end
      KIND_H53: begin
        h[1] = Sig53; h[3] = 8'h00;
        h[0] = $urandom_range(1) ? 8'h08 : 8'h0c;
      end
      default: ;
    endcase
    if (corrupt) begin
      k = $urandom_range(HeadLen + TagLen - 1);
      if (k < HeadLen) h[k] = 8'($urandom);
      else t[k - HeadLen] = 8'($urandom);
    end
    n = (pkt_len > 120) ? 120 : pkt_len;
    if (kind == KIND_OPB_74) n = $urandom_range(113, 102);
    // short packets leave bytes unseen, long ones run past the length
    r = $urandom_range(7);
    if (r == 0) n = $urandom_range(n, 1);
    else if (r == 1) n += $urandom_range(8, 1);
    pkt_bytes.delete();
    for (int unsigned i = 0; i < n; i++) begin
      if (i < HeadLen) pkt_bytes.push_back(h[i]);
      else if (i >= TagFirst && i < TagFirst + TagLen) pkt_bytes.push_back(t[i - TagFirst]);
      else pkt_bytes.push_back(8'($urandom));
    end
    r = $urandom_range(9);
    pkt_sp = 16'($urandom);
    pkt_dp = 16'($urandom);
    if (r < 4) pkt_dp = svc_port;
    else if (r < 8) pkt_sp = svc_port;
    pkt_udp = ($urandom_range(9) != 0);
  endtask

  // ------------------------------------------------------------ verdict check

  always @(posedge clk_i) begin : verdict_check
    class_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("verdict item %h with none expected", m_axis_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (m_axis_tdata[1:0] !== want.verdict)
          flag_error($sformatf("verdict exp %0d got %0d", want.verdict, m_axis_tdata[1:0]));
        if (m_axis_tdata[17:2] !== want.detections)
          flag_error($sformatf("detections exp %0d got %0d", want.detections,
                               m_axis_tdata[17:2]));
        if (m_axis_tdata[23:18] !== '0)
          flag_error($sformatf("padding exp 0 got %h", m_axis_tdata[23:18]));
      end
    end
    // hold tready low in bursts of random length
    if (ready_hold != 0) begin
      m_axis_tready <= 1'b0;
      ready_hold--;
    end else if (idle_pct_out != 0 && $urandom_range(99) < idle_pct_out) begin
      m_axis_tready <= 1'b0;
      ready_hold = $urandom_range(5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_field_extremes();
    // not UDP, every field at its top value
    pkt_udp = 1'b0; pkt_sp = 16'hffff; pkt_dp = 16'hffff; pkt_len = 16'hffff;
    pkt_bytes = '{8'hff};
    send_packet();
    // zero length fails every length test
    pkt_udp = 1'b1; pkt_sp = 16'h0000; pkt_dp = svc_port; pkt_len = 16'd0;
    pkt_bytes = '{8'h00, Sig80};
    send_packet();
    // bytes that never arrive read as zero, so bytes 3 and 4 match
    pkt_len = 16'd30;
    pkt_bytes = '{8'h00, Sig80};
    send_packet();
    // same packet on other ports
    pkt_sp = svc_port + 16'd1; pkt_dp = svc_port - 16'd1;
    send_packet();
  endtask

  task automatic test_bytes_past_length();
    // opcode 0x55 short form: bytes 18 to 20 lie past the length and read as zero
    pkt_udp = 1'b1; pkt_sp = svc_port; pkt_dp = 16'h0000; pkt_len = 16'd18;
    pkt_bytes.delete();
    for (int i = 0; i < HeadLen; i++) pkt_bytes.push_back(i >= 18 ? 8'hff : 8'h00);
    pkt_bytes[0] = 8'd18;
    pkt_bytes[2] = OpC;
    send_packet();
  endtask

  task automatic test_each_signature();
    for (int unsigned k = KIND_NOISE; k <= KIND_H53; k++) begin
      build_packet(sig_kind_e'(k), 1'b0);
      pkt_udp = 1'b1;
      pkt_dp  = svc_port;
      send_packet();
    end
  endtask

  task automatic test_service_port_settings();
    logic [15:0] ports [4];
    ports = '{16'h0000, 16'hffff, 16'($urandom), ServicePortReset};
    foreach (ports[p]) begin
      write_service_port(ports[p]);
      repeat (4) begin
        build_packet(sig_kind_e'($urandom_range(KIND_H53)), $urandom_range(3) == 0);
        send_packet();
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start_packets, r;
    start_packets = packets_sent;
    while (items_sent < 1500) begin
      // quiet stretches without any idling
      idle_pct_in  = (packets_sent % 10 < 3) ? 0 : 25;
      idle_pct_out = (packets_sent % 10 < 3) ? 0 : 25;
      if ((packets_sent - start_packets) % 15 == 14) begin
        r = $urandom_range(3);
        write_service_port(r == 0 ? 16'h0000 : r == 1 ? 16'hffff :
                           r == 2 ? ServicePortReset : 16'($urandom));
      end
      build_packet(sig_kind_e'($urandom_range(KIND_H53)), $urandom_range(3) == 0);
      send_packet();
    end
  endtask

  task automatic test_back_to_back();
    // no idling on either side: items follow each other with no gap
    idle_pct_in  = 0;
    idle_pct_out = 0;
    while (items_sent < 1750) begin
      build_packet(sig_kind_e'($urandom_range(KIND_H53)), $urandom_range(3) == 0);
      send_packet();
    end
  endtask

  initial begin
    svc_port = ServicePortReset;
    det_cnt  = '0;
    clear_capture();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct_in  = 25;
    idle_pct_out = 25;
    test_field_extremes();
    test_bytes_past_length();
    test_each_signature();
    test_service_port_settings();
    test_random_traffic();
    test_back_to_back();
    drain_verdicts();
    repeat (8) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      flag_error($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    $display("streamed %0d bytes in %0d packets over %0d service port settings",
             items_sent, packets_sent, port_writes);
    $display("checked %0d verdicts, detection count ended at %0d, %0d mismatches",
             verdicts_checked, det_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("[udp_payload_signature_classifier] OK");
    end else begin
      $display("[udp_payload_signature_classifier] ERROR");
    end
    $finish;
  end

endmodule
